@@ sv/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, round constants and helper functions.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned DIGEST_WORDS = 8;
    localparam int unsigned BLOCK_BYTES  = 64;
    localparam int unsigned ROUNDS       = 64;
    localparam logic [60:0] MAX_BYTES    = {61{1'b1}};
    localparam logic [7:0]  PAD_BYTE     = 8'h80;
    localparam logic [5:0]  LEN_START    = 6'd56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COMP,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       push_en;    // write push_byte into the block words
        logic [7:0] push_byte;
        logic       count_byte; // advance the message byte count
        logic       comp_start; // load working registers
        logic       comp_round; // run one round
        logic       comp_final; // add working set into chain
        logic       msg_clear;  // back to initial state
        logic       out_shift;  // advance the digest output word
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [5:0]  fill;
        logic [5:0]  round;
        logic [63:0] bit_len;
    } dp_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        case (i)
            3'd0: init_h = 32'h6a09e667;
            3'd1: init_h = 32'hbb67ae85;
            3'd2: init_h = 32'h3c6ef372;
            3'd3: init_h = 32'ha54ff53a;
            3'd4: init_h = 32'h510e527f;
            3'd5: init_h = 32'h9b05688c;
            3'd6: init_h = 32'h1f83d9ab;
            default: init_h = 32'h5be0cd19;
        endcase
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

@@ sv/sha_datapath.sv @@
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block words and schedule window, round unit, chain and length count.
// ----------------------------------------------------------------------------
module sha_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  sha_pkg::dp_cmd_t    cmd,
    output sha_pkg::dp_stat_t   stat,
    output logic                ovf,
    output logic [31:0]         out_word
);

    logic [5:0]  fill_reg, fill_next;
    logic [60:0] total_reg;
    logic        ovf_reg;
    logic [31:0] h_reg [8];
    logic [31:0] wk_reg [8];    // a..h
    logic [31:0] w_reg [16];    // block words, then schedule window, w_reg[0] is w[t]
    logic [5:0]  round_reg;

    logic [31:0] t1, t2, s0, s1, w_new;

    always_comb begin
        fill_next = fill_reg + 6'd1;
        t1 = wk_reg[7] + (sha_pkg::rotr(wk_reg[4], 6) ^ sha_pkg::rotr(wk_reg[4], 11)
             ^ sha_pkg::rotr(wk_reg[4], 25)) + ((wk_reg[4] & wk_reg[5]) ^ (~wk_reg[4] & wk_reg[6]))
             + sha_pkg::ROUND_K[round_reg] + w_reg[0];
        t2 = (sha_pkg::rotr(wk_reg[0], 2) ^ sha_pkg::rotr(wk_reg[0], 13)
             ^ sha_pkg::rotr(wk_reg[0], 22))
             + ((wk_reg[0] & wk_reg[1]) ^ (wk_reg[0] & wk_reg[2]) ^ (wk_reg[1] & wk_reg[2]));
        s0 = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha_pkg::init_h(3'(i));
            end
        end else begin
            if (cmd.push_en) begin
                fill_reg <= fill_next;
            end
            if (cmd.count_byte) begin
                if (total_reg == sha_pkg::MAX_BYTES) begin
                    ovf_reg <= 1'b1;
                end else begin
                    total_reg <= total_reg + 61'd1;
                end
            end
            if (cmd.comp_start) begin
                round_reg <= '0;
            end else if (cmd.comp_round) begin
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.comp_final) begin
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= h_reg[i] + wk_reg[i];
                end
            end else if (cmd.out_shift) begin
                // rotate so the next digest word moves to the front
                for (int i = 0; i < 7; i++) begin
                    h_reg[i] <= h_reg[i + 1];
                end
                h_reg[7] <= h_reg[0];
            end
            if (cmd.msg_clear) begin
                total_reg <= '0;
                ovf_reg   <= 1'b0;
                fill_reg  <= '0;
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= sha_pkg::init_h(3'(i));
                end
            end
        end
    end

    // working set and schedule window, no reset
    always_ff @(posedge aclk) begin
        if (cmd.comp_start) begin
            for (int i = 0; i < 8; i++) begin
                wk_reg[i] <= h_reg[i];
            end
        end else if (cmd.comp_round) begin
            wk_reg[0] <= t1 + t2;
            wk_reg[1] <= wk_reg[0];
            wk_reg[2] <= wk_reg[1];
            wk_reg[3] <= wk_reg[2];
            wk_reg[4] <= wk_reg[3] + t1;
            wk_reg[5] <= wk_reg[4];
            wk_reg[6] <= wk_reg[5];
            wk_reg[7] <= wk_reg[6];
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end else if (cmd.push_en) begin
            // gather bytes big-endian into the block words
            w_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= cmd.push_byte;
        end
    end

    assign stat.fill    = fill_reg;
    assign stat.round   = round_reg;
    assign stat.bit_len = {total_reg, 3'b000};
    assign ovf          = ovf_reg;
    assign out_word     = h_reg[0];

endmodule

@@ sv/sha_ctrl.sv @@
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, compression, padding and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          in_byte,
    input  logic                in_bvalid,
    input  logic                in_eom,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2:0]          out_idx,
    output sha_pkg::dp_cmd_t    cmd,
    input  sha_pkg::dp_stat_t   stat
);

    sha_pkg::state_t state_reg, state_next;
    logic       pad_reg, pad_next;       // message is closing
    logic       padded_reg, padded_next; // 0x80 already written
    logic       wrap_reg, wrap_next;     // length goes into the next block
    logic       done_reg, done_next;     // length written, digest follows
    logic [2:0] idx_reg, idx_next;
    logic       full;
    logic [2:0] len_sel;

    assign full    = (stat.fill == 6'd63);
    assign len_sel = 3'(stat.fill - sha_pkg::LEN_START);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sha_pkg::ST_IDLE;
            pad_reg    <= 1'b0;
            padded_reg <= 1'b0;
            wrap_reg   <= 1'b0;
            done_reg   <= 1'b0;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            pad_reg    <= pad_next;
            padded_reg <= padded_next;
            wrap_reg   <= wrap_next;
            done_reg   <= done_next;
            idx_reg    <= idx_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        pad_next    = pad_reg;
        padded_next = padded_reg;
        wrap_next   = wrap_reg;
        done_next   = done_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        unique case (state_reg)
            sha_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (in_bvalid) begin
                        cmd.push_en    = 1'b1;
                        cmd.push_byte  = in_byte;
                        cmd.count_byte = 1'b1;
                    end
                    if (in_bvalid && full) begin
                        state_next = sha_pkg::ST_LOAD;
                        pad_next   = in_eom;
                    end else if (in_eom) begin
                        state_next = sha_pkg::ST_PAD;
                        pad_next   = 1'b1;
                    end
                end
            end
            sha_pkg::ST_LOAD: begin
                cmd.comp_start = 1'b1;
                state_next     = sha_pkg::ST_COMP;
            end
            sha_pkg::ST_COMP: begin
                cmd.comp_round = 1'b1;
                if (stat.round == 6'd63) begin
                    state_next = sha_pkg::ST_ADD;
                end
            end
            sha_pkg::ST_ADD: begin
                cmd.comp_final = 1'b1;
                if (!pad_reg) begin
                    state_next = sha_pkg::ST_IDLE;
                end else if (done_reg) begin
                    state_next = sha_pkg::ST_OUT;
                end else begin
                    state_next = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_PAD: begin
                cmd.push_en = 1'b1;
                if (!padded_reg) begin
                    cmd.push_byte = sha_pkg::PAD_BYTE;
                    padded_next   = 1'b1;
                    // no room for the length behind the marker
                    wrap_next     = (stat.fill >= sha_pkg::LEN_START);
                end else if (stat.fill >= sha_pkg::LEN_START && !wrap_reg) begin
                    cmd.push_byte = stat.bit_len[{~len_sel, 3'b000} +: 8];
                end else begin
                    cmd.push_byte = 8'h00;
                end
                if (full) begin
                    state_next = sha_pkg::ST_LOAD;
                    done_next  = padded_reg && !wrap_reg;
                    wrap_next  = 1'b0;
                end
            end
            sha_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmd.msg_clear = 1'b1;
                        pad_next      = 1'b0;
                        padded_next   = 1'b0;
                        done_next     = 1'b0;
                        state_next    = sha_pkg::ST_IDLE;
                    end else begin
                        cmd.out_shift = 1'b1;
                    end
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    assign out_idx = idx_reg;

endmodule

@@ sv/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 engine with padding and eight-word digest output.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one word per handshake, tdata = data_byte, tuser bit 0 =
//   byte_valid, tlast = end_of_message. Words without a byte or end are
//   taken and dropped.
//   Master channel: eight words per message, tdata = digest_word, tuser =
//   word_index then size_overflow from the lowest bit up, tlast on word 7.
//   Throughput: one byte per cycle while a block fills; the 64th byte of a
//   block stalls intake while the block compresses (load, 64 rounds of the
//   single round unit, chain add). Closing a message with f bytes held pads
//   one byte per cycle up to the end of the block, then compresses it; when
//   f is 56 or more a second block of padding and length follows. A closing
//   byte that completes a block adds its own compression first. The digest
//   then leaves one word per cycle while the receiver is ready. A stalled
//   receiver holds the current digest word and blocks intake until all eight
//   words leave. Reset loads the initial hash and clears counts and flags.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic [3:0]  m_tuser,   // word_index[2:0], size_overflow
    output logic        m_tlast    // last_word
);

    sha_pkg::dp_cmd_t  cmd;
    sha_pkg::dp_stat_t stat;
    logic              ovf;
    logic [2:0]        idx;

    sha_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_byte   (s_tdata),
        .in_bvalid (s_tuser),
        .in_eom    (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_idx   (idx),
        .cmd       (cmd),
        .stat      (stat)
    );

    sha_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .ovf      (ovf),
        .out_word (m_tdata)
    );

    assign m_tuser = {ovf, idx};
    assign m_tlast = (idx == 3'd7);

endmodule

@@ test/tb_sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte messages through the slave stream, hashes them in a local
// SHA-256 model and compares every digest word that leaves the master stream.
// ----------------------------------------------------------------------------

// Local SHA-256 model: absorbs accepted input words, queues digest words.
class sha_digest_model;
    typedef struct {
        bit [31:0] word;
        bit [2:0]  index;
        bit        last;
        bit        err;
    } digest_word_t;

    localparam bit [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam bit [63:0] LEN_LIMIT = 64'h1FFF_FFFF_FFFF_FFFF;

    bit [31:0]    hash_state [8];
    bit [7:0]     block_buf [64];
    int unsigned  fill;
    bit [63:0]    msg_bytes;
    bit           too_long;
    digest_word_t expected_words [$];
    int unsigned  mismatches;

    function new();
        hash_state = IV;
        fill       = 0;
        msg_bytes  = 0;
        too_long   = 0;
        mismatches = 0;
    endfunction

    function bit [31:0] ror(bit [31:0] v, int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function void compress();
        bit [31:0] w [64];
        bit [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        {a, b, c, d} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
        {e, f, g, h} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                 + sha_pkg::ROUND_K[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function void push(bit [7:0] v);
        block_buf[fill] = v;
        fill++;
        if (fill == 64) begin
            compress();
            fill = 0;
        end
    endfunction

    // Note one accepted input word; on end of message queue the digest.
    function void absorb_word(bit [7:0] data, bit has_byte, bit eom);
        bit [63:0]    bit_len;
        digest_word_t dw;
        if (has_byte) begin
            if (msg_bytes >= LEN_LIMIT)
                too_long = 1;
            else
                msg_bytes++;
            push(data);
        end
        if (!eom)
            return;
        bit_len = msg_bytes << 3;
        push(sha_pkg::PAD_BYTE);
        while (fill != 56)
            push(8'h00);
        for (int i = 0; i < 8; i++)
            push(bit_len[63 - 8*i -: 8]);
        for (int i = 0; i < 8; i++) begin
            dw.word  = hash_state[i];
            dw.index = i[2:0];
            dw.last  = (i == 7);
            dw.err   = too_long;
            expected_words.push_back(dw);
        end
        hash_state = IV;
        fill       = 0;
        msg_bytes  = 0;
        too_long   = 0;
    endfunction

    task report_mismatch(string what, bit [31:0] got, bit [31:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    // Check one digest word from the master stream against the oldest expectation.
    task check_digest_word(bit [31:0] tdata, bit [3:0] tuser, bit tlast);
        digest_word_t dw;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected digest word", tdata, 32'd0);
            return;
        end
        dw = expected_words.pop_front();
        if (tdata != dw.word)
            report_mismatch("digest_word", tdata, dw.word);
        if (tuser[2:0] != dw.index)
            report_mismatch("word_index", 32'(tuser[2:0]), 32'(dw.index));
        if (tuser[3] != dw.err)
            report_mismatch("size_overflow", 32'(tuser[3]), 32'(dw.err));
        if (tlast != dw.last)
            report_mismatch("last_word", 32'(tlast), 32'(dw.last));
    endtask
endclass

module tb_sha256_stream_hasher;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned HOLD_CYCLES  = 300;   // long receiver stall
    localparam int unsigned HOLD_AT      = 60;    // words sent before the stall
    localparam int unsigned DRAIN_CYCLES = 200;   // > two compressions plus output

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // data_byte
    logic        s_tuser  = 1'b0;    // byte_valid
    logic        s_tlast  = 1'b0;    // end_of_message
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // digest_word
    logic [3:0]  m_tuser;            // word_index[2:0], size_overflow
    logic        m_tlast;            // last_word

    sha_digest_model digests = new();

    int unsigned send_idle_pct = 23;
    int unsigned recv_idle_pct = 77;
    int unsigned words_sent    = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 0;
    int unsigned cycle_count   = 0;

    sha256_stream_hasher dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #4 aclk = ~aclk;

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_sha256_stream_hasher: done, errors");
            $finish;
        end
    end

    // Receiver: random backpressure, plus one long hold-off once enough
    // words went in, so that a pending digest stalls the block's input.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_sent >= HOLD_AT) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: check every digest word that completes a handshake.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            digests.check_digest_word(m_tdata, m_tuser, m_tlast);
    end

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic [7:0] data, input logic has_byte, input logic eom);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= eom;
        do @(posedge aclk); while (!s_tready);
        digests.absorb_word(data, has_byte, eom);
        words_sent++;
    endtask

    // Send a message of len bytes with random content and some dropped
    // filler words; close either on the last byte or with a bare end word.
    task automatic send_message(input int unsigned len);
        bit close_on_byte;
        close_on_byte = (len > 0) && ($urandom_range(1) != 0);
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0)
                send_word(8'($urandom_range(255)), 1'b0, 1'b0);
            send_word(8'($urandom_range(255)), 1'b1, close_on_byte && (k == len - 1));
        end
        if (!close_on_byte)
            send_word(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    initial begin
        int unsigned len;
        int unsigned pick;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: dropped word, empty message, byte extremes, end with and
        // without a byte, filler word inside a message.
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h5A, 1'b0, 1'b0);
        send_word(8'h80, 1'b1, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h01, 1'b1, 1'b1);

        // Random messages; occasional lengths at the padding boundaries force
        // the one- and two-block closing paths.
        for (int unsigned item = 0; item < 100; item += len + 1) begin
            if (item >= 33 && item < 66) begin
                send_idle_pct = 77;
                recv_idle_pct = 23;
            end else if (item >= 66) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 12) begin
                case ($urandom_range(5))
                    0: len = 55;
                    1: len = 56;
                    2: len = 63;
                    3: len = 64;
                    4: len = 65;
                    default: len = 119;
                endcase
            end else begin
                len = $urandom_range(9);
            end
            send_message(len);
        end
        s_tvalid <= 1'b0;

        while (digests.expected_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (digests.mismatches == 0)
            $display("tb_sha256_stream_hasher: done, clean");
        else
            $display("tb_sha256_stream_hasher: done, errors");
        $finish;
    end

endmodule

@@ sha256_stream_hasher.f @@
sv/sha_pkg.sv
sv/sha_datapath.sv
sv/sha_ctrl.sv
sv/sha256_stream_hasher.sv
test/tb_sha256_stream_hasher.sv
